/* rtl/sts_pkg.sv */
`timescale 1ns / 1ps

package sts_pkg;

	localparam int KEYWORD_COUNT = 22;
	localparam int KW_BYTES      = 8;
	localparam int FIFO_DEPTH    = 4;

	typedef logic [4:0] kind_t;

	localparam kind_t KIND_TEXT    = 5'd0;
	localparam kind_t KIND_IDENT   = 5'd1;
	localparam kind_t KIND_NUMBER  = 5'd2;
	localparam kind_t KIND_LITERAL = 5'd3;
	localparam kind_t KIND_KEYWORD = 5'd4;
	localparam kind_t KIND_COLON   = 5'd5;
	localparam kind_t KIND_SEMI    = 5'd6;
	localparam kind_t KIND_HASH    = 5'd7;
	localparam kind_t KIND_LBRACE  = 5'd8;
	localparam kind_t KIND_RBRACE  = 5'd9;
	localparam kind_t KIND_LPAREN  = 5'd10;
	localparam kind_t KIND_RPAREN  = 5'd11;
	localparam kind_t KIND_COMMA   = 5'd12;
	localparam kind_t KIND_DOLLAR  = 5'd13;
	localparam kind_t KIND_ASSIGN  = 5'd14;
	localparam kind_t KIND_EQ      = 5'd15;
	localparam kind_t KIND_LT      = 5'd16;
	localparam kind_t KIND_LE      = 5'd17;
	localparam kind_t KIND_GT      = 5'd18;
	localparam kind_t KIND_GE      = 5'd19;
	localparam kind_t KIND_AMP     = 5'd20;
	localparam kind_t KIND_ANDAND  = 5'd21;
	localparam kind_t KIND_BAR     = 5'd22;
	localparam kind_t KIND_OROR    = 5'd23;
	localparam kind_t KIND_DONE    = 5'd24;
	localparam kind_t KIND_ERROR   = 5'd25;
	localparam kind_t KIND_SLASH   = 5'd26;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_X   = 8'h58;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// keyword text, right-justified and zero-padded, as the byte window holds it
	localparam logic [8*KW_BYTES-1:0] KW_TEXT [KEYWORD_COUNT] = '{
		"if", "else", "endif", "for", "while", "switch", "case", "do",
		"break", "continue", "goto", "unsigned", "enum", "typedef", "struct",
		"include", "define", "state", "cts", "stc", "start", "end"
	};

	typedef enum logic [12:0] {
		MODE_START  = 13'b0000000000001,
		MODE_IDENT  = 13'b0000000000010,
		MODE_NUMBER = 13'b0000000000100,
		MODE_STRING = 13'b0000000001000,
		MODE_EQ     = 13'b0000000010000,
		MODE_LT     = 13'b0000000100000,
		MODE_GT     = 13'b0000001000000,
		MODE_AMP    = 13'b0000010000000,
		MODE_BAR    = 13'b0000100000000,
		MODE_SLASH  = 13'b0001000000000,
		MODE_LINEC  = 13'b0010000000000,
		MODE_BLOCK  = 13'b0100000000000,
		MODE_BSTAR  = 13'b1000000000000
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  kw;
		logic [7:0]  chr;
		logic [15:0] line;
		logic [5:0]  len;
		logic        ovf;
		logic        last;
	} res_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] idx;
	} kw_res_t;

	function automatic kw_res_t kw_lookup(logic [8*KW_BYTES-1:0] w);
		kw_res_t r;
		r = '0;
		for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
			if (w == KW_TEXT[i]) begin
				r.hit = 1'b1;
				r.idx = 5'(i);
			end
		end
		return r;
	endfunction

endpackage

/* rtl/script_token_scanner.sv */
`timescale 1ns / 1ps

// Streaming scanner for a small C-like script language. One source byte per
// word enters on the char channel; a zero byte ends the text and resets the
// line count. Each byte gives zero, one or two result words on the token
// channel: echoed text bytes of identifiers, numbers and literals, a kind word
// when a token ends (keywords named by index), operators, punctuation, errors
// and done. A byte is taken every cycle while the input does not stall; it is
// held in an input register, then its results go into a four-word output
// queue that drains one word per cycle while the token channel does not stall,
// so bytes that give two words run at the output's pace. Input stalls while a
// byte waits in the input register and the queue holds more than two words.
module script_token_scanner #(
	parameter int MAX_TOKEN_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [4:0]  token_kind,
	output logic [4:0]  keyword_index,
	output logic [7:0]  text_char,
	output logic [15:0] line_number,
	output logic [5:0]  text_length,
	output logic        length_overflow,
	output logic        last_of_run
);

	localparam logic [5:0] MAX_LEN = 6'(MAX_TOKEN_LEN);
	localparam int PTR_W = $clog2(sts_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(sts_pkg::FIFO_DEPTH + 1);

	typedef struct packed {
		logic [5:0]  cnt;
		logic        over;
		logic [63:0] win;
		logic [7:0]  prev;
		logic        echo;
	} tok_t;

	function automatic tok_t take(logic [5:0] cnt, logic over, logic [63:0] win,
		logic [7:0] b);
		tok_t t;
		t.cnt  = cnt;
		t.over = over;
		t.echo = 1'b0;
		if (cnt < MAX_LEN) begin
			t.cnt  = cnt + 6'd1;
			t.echo = 1'b1;
		end else begin
			t.over = 1'b1;
		end
		t.win  = {win[55:0], b};
		t.prev = b;
		return t;
	endfunction

	logic               valid_s1;
	logic [7:0]         char_s1;
	sts_pkg::mode_t     mode_q, mode_v;
	logic [15:0]        line_q, line_v;
	logic [5:0]         cnt_q, cnt_v;
	logic               over_q, over_v;
	logic [63:0]        win_q, win_v;
	logic [7:0]         prev_q, prev_v;

	sts_pkg::res_t      fifo_q [sts_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]   rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]   fcnt_q;

	sts_pkg::res_t      res_v [2];
	logic [1:0]         n_v;
	logic               s1_go, proc, pop;
	logic [1:0]         push_n;
	sts_pkg::kw_res_t   kw;
	logic               kw_ok;
	tok_t               tk;
	logic               b_alpha, b_digit;
	logic               take1, take2, fin, fresh, bump1;
	sts_pkg::kind_t     fin_kind, single_kind;
	logic               single, err1;

	assign s1_go      = fcnt_q <= CNT_W'(2);
	assign char_stall = valid_s1 && !s1_go;
	assign proc       = valid_s1 && s1_go;
	assign pop        = token_valid && !token_stall;
	assign push_n     = proc ? n_v : 2'd0;

	assign kw    = sts_pkg::kw_lookup(win_q);
	assign kw_ok = kw.hit && !over_q && (cnt_q <= 6'd8);

	assign b_alpha = ((char_s1 >= sts_pkg::CH_LC_A) && (char_s1 <= sts_pkg::CH_LC_Z)) ||
		((char_s1 >= sts_pkg::CH_UC_A) && (char_s1 <= sts_pkg::CH_UC_Z));
	assign b_digit = (char_s1 >= sts_pkg::CH_ZERO) && (char_s1 <= sts_pkg::CH_NINE);

	always_comb begin
		mode_v      = mode_q;
		line_v      = line_q;
		cnt_v       = cnt_q;
		over_v      = over_q;
		win_v       = win_q;
		prev_v      = prev_q;
		n_v         = 2'd0;
		res_v[0]    = '0;
		res_v[1]    = '0;
		take1       = 1'b0;
		take2       = 1'b0;
		fin         = 1'b0;
		fin_kind    = sts_pkg::KIND_IDENT;
		single      = 1'b0;
		single_kind = sts_pkg::KIND_ASSIGN;
		err1        = 1'b0;
		bump1       = 1'b0;
		fresh       = 1'b0;
		tk          = '0;

		unique case (mode_q)
			sts_pkg::MODE_IDENT: begin
				if (b_alpha || b_digit || char_s1 == sts_pkg::CH_UNDER) begin
					take1 = 1'b1;
				end else begin
					fin      = 1'b1;
					fin_kind = sts_pkg::KIND_IDENT;
					fresh    = 1'b1;
				end
			end
			sts_pkg::MODE_NUMBER: begin
				if (b_digit || char_s1 == sts_pkg::CH_DOT ||
					((char_s1 == sts_pkg::CH_LC_X || char_s1 == sts_pkg::CH_UC_X) &&
					prev_q == sts_pkg::CH_ZERO)) begin
					take1 = 1'b1;
				end else begin
					fin      = 1'b1;
					fin_kind = sts_pkg::KIND_NUMBER;
					fresh    = 1'b1;
				end
			end
			sts_pkg::MODE_STRING: begin
				if (char_s1 == sts_pkg::CH_QUOTE) begin
					fin      = 1'b1;
					fin_kind = sts_pkg::KIND_LITERAL;
				end else if (char_s1 == sts_pkg::CH_NUL) begin
					err1  = 1'b1;
					fresh = 1'b1;
				end else begin
					take1 = 1'b1;
					bump1 = char_s1 == sts_pkg::CH_LF;
				end
			end
			sts_pkg::MODE_EQ, sts_pkg::MODE_LT, sts_pkg::MODE_GT: begin
				single = 1'b1;
				mode_v = sts_pkg::MODE_START;
				if (char_s1 == sts_pkg::CH_EQ) begin
					single_kind = (mode_q == sts_pkg::MODE_EQ) ? sts_pkg::KIND_EQ :
						(mode_q == sts_pkg::MODE_LT) ? sts_pkg::KIND_LE : sts_pkg::KIND_GE;
				end else begin
					single_kind = (mode_q == sts_pkg::MODE_EQ) ? sts_pkg::KIND_ASSIGN :
						(mode_q == sts_pkg::MODE_LT) ? sts_pkg::KIND_LT : sts_pkg::KIND_GT;
					fresh = 1'b1;
				end
			end
			sts_pkg::MODE_AMP: begin
				single = 1'b1;
				mode_v = sts_pkg::MODE_START;
				if (char_s1 == sts_pkg::CH_AMP) begin
					single_kind = sts_pkg::KIND_ANDAND;
				end else begin
					single_kind = sts_pkg::KIND_AMP;
					fresh       = 1'b1;
				end
			end
			sts_pkg::MODE_BAR: begin
				single = 1'b1;
				mode_v = sts_pkg::MODE_START;
				if (char_s1 == sts_pkg::CH_BAR) begin
					single_kind = sts_pkg::KIND_OROR;
				end else begin
					single_kind = sts_pkg::KIND_BAR;
					fresh       = 1'b1;
				end
			end
			sts_pkg::MODE_SLASH: begin
				if (char_s1 == sts_pkg::CH_SLASH) begin
					mode_v = sts_pkg::MODE_LINEC;
				end else if (char_s1 == sts_pkg::CH_STAR) begin
					mode_v = sts_pkg::MODE_BLOCK;
				end else begin
					single      = 1'b1;
					single_kind = sts_pkg::KIND_SLASH;
					fresh       = 1'b1;
				end
			end
			sts_pkg::MODE_LINEC: begin
				if (char_s1 == sts_pkg::CH_NUL) begin
					fresh = 1'b1;
				end else if (char_s1 == sts_pkg::CH_LF) begin
					bump1  = 1'b1;
					mode_v = sts_pkg::MODE_START;
				end
			end
			sts_pkg::MODE_BLOCK, sts_pkg::MODE_BSTAR: begin
				if (char_s1 == sts_pkg::CH_NUL) begin
					fresh = 1'b1;
				end else if (char_s1 == sts_pkg::CH_SLASH && mode_q == sts_pkg::MODE_BSTAR) begin
					mode_v = sts_pkg::MODE_START;
				end else if (char_s1 == sts_pkg::CH_STAR) begin
					mode_v = sts_pkg::MODE_BSTAR;
				end else begin
					bump1  = char_s1 == sts_pkg::CH_LF;
					mode_v = sts_pkg::MODE_BLOCK;
				end
			end
			default: fresh = 1'b1;
		endcase

		// first part: the current token or pending operator
		if (take1) begin
			tk     = take(cnt_v, over_v, win_v, char_s1);
			cnt_v  = tk.cnt;
			over_v = tk.over;
			win_v  = tk.win;
			prev_v = tk.prev;
			if (tk.echo) begin
				res_v[n_v[0]].kind = sts_pkg::KIND_TEXT;
				res_v[n_v[0]].chr  = char_s1;
				res_v[n_v[0]].line = line_v;
				res_v[n_v[0]].len  = cnt_v;
				n_v = n_v + 2'd1;
			end
		end
		if (fin) begin
			res_v[n_v[0]].kind = (fin_kind == sts_pkg::KIND_IDENT && kw_ok) ?
				sts_pkg::KIND_KEYWORD : fin_kind;
			res_v[n_v[0]].kw   = (fin_kind == sts_pkg::KIND_IDENT && kw_ok) ? kw.idx : 5'd0;
			res_v[n_v[0]].line = line_v;
			res_v[n_v[0]].len  = cnt_q;
			res_v[n_v[0]].ovf  = over_q;
			n_v    = n_v + 2'd1;
			mode_v = sts_pkg::MODE_START;
		end
		if (err1) begin
			res_v[n_v[0]].kind = sts_pkg::KIND_ERROR;
			res_v[n_v[0]].line = line_v;
			n_v = n_v + 2'd1;
		end
		if (fin || err1) begin
			cnt_v  = '0;
			over_v = 1'b0;
			win_v  = '0;
			prev_v = '0;
		end
		if (single) begin
			res_v[n_v[0]].kind = single_kind;
			res_v[n_v[0]].line = line_v;
			n_v = n_v + 2'd1;
		end
		if (bump1 && line_v != 16'hFFFF) begin
			line_v = line_v + 16'd1;
		end

		// second part: the byte scanned from start
		if (fresh) begin
			mode_v = sts_pkg::MODE_START;
			unique case (char_s1)
				sts_pkg::CH_NUL: begin
					res_v[n_v[0]].kind = sts_pkg::KIND_DONE;
					res_v[n_v[0]].line = line_v;
					n_v    = n_v + 2'd1;
					line_v = 16'd1;
				end
				sts_pkg::CH_LF: begin
					if (line_v != 16'hFFFF) begin
						line_v = line_v + 16'd1;
					end
				end
				sts_pkg::CH_SPACE, sts_pkg::CH_TAB, sts_pkg::CH_CR: ;
				sts_pkg::CH_QUOTE: begin
					cnt_v  = '0;
					over_v = 1'b0;
					win_v  = '0;
					prev_v = '0;
					mode_v = sts_pkg::MODE_STRING;
				end
				sts_pkg::CH_EQ:    mode_v = sts_pkg::MODE_EQ;
				sts_pkg::CH_LT:    mode_v = sts_pkg::MODE_LT;
				sts_pkg::CH_GT:    mode_v = sts_pkg::MODE_GT;
				sts_pkg::CH_AMP:   mode_v = sts_pkg::MODE_AMP;
				sts_pkg::CH_BAR:   mode_v = sts_pkg::MODE_BAR;
				sts_pkg::CH_SLASH: mode_v = sts_pkg::MODE_SLASH;
				sts_pkg::CH_COLON, sts_pkg::CH_SEMI, sts_pkg::CH_HASH, sts_pkg::CH_LBRACE,
				sts_pkg::CH_RBRACE, sts_pkg::CH_LPAREN, sts_pkg::CH_RPAREN, sts_pkg::CH_COMMA,
				sts_pkg::CH_DOLLAR: begin
					unique case (char_s1)
						sts_pkg::CH_COLON:  res_v[n_v[0]].kind = sts_pkg::KIND_COLON;
						sts_pkg::CH_SEMI:   res_v[n_v[0]].kind = sts_pkg::KIND_SEMI;
						sts_pkg::CH_HASH:   res_v[n_v[0]].kind = sts_pkg::KIND_HASH;
						sts_pkg::CH_LBRACE: res_v[n_v[0]].kind = sts_pkg::KIND_LBRACE;
						sts_pkg::CH_RBRACE: res_v[n_v[0]].kind = sts_pkg::KIND_RBRACE;
						sts_pkg::CH_LPAREN: res_v[n_v[0]].kind = sts_pkg::KIND_LPAREN;
						sts_pkg::CH_RPAREN: res_v[n_v[0]].kind = sts_pkg::KIND_RPAREN;
						sts_pkg::CH_COMMA:  res_v[n_v[0]].kind = sts_pkg::KIND_COMMA;
						default:            res_v[n_v[0]].kind = sts_pkg::KIND_DOLLAR;
					endcase
					res_v[n_v[0]].line = line_v;
					n_v = n_v + 2'd1;
				end
				default: begin
					if (b_alpha || b_digit) begin
						take2  = 1'b1;
						mode_v = b_alpha ? sts_pkg::MODE_IDENT : sts_pkg::MODE_NUMBER;
					end else begin
						res_v[n_v[0]].kind = sts_pkg::KIND_ERROR;
						res_v[n_v[0]].line = line_v;
						n_v = n_v + 2'd1;
					end
				end
			endcase
		end
		if (take2) begin
			tk     = take(6'd0, 1'b0, 64'd0, char_s1);
			cnt_v  = tk.cnt;
			over_v = tk.over;
			win_v  = tk.win;
			prev_v = tk.prev;
			if (tk.echo) begin
				res_v[n_v[0]].kind = sts_pkg::KIND_TEXT;
				res_v[n_v[0]].chr  = char_s1;
				res_v[n_v[0]].line = line_v;
				res_v[n_v[0]].len  = cnt_v;
				n_v = n_v + 2'd1;
			end
		end

		if (n_v == 2'd1) begin
			res_v[0].last = 1'b1;
		end else if (n_v == 2'd2) begin
			res_v[1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			char_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sts_pkg::MODE_START;
			line_q <= 16'd1;
			cnt_q  <= '0;
			over_q <= 1'b0;
			win_q  <= '0;
			prev_q <= '0;
		end else if (proc) begin
			mode_q <= mode_v;
			line_q <= line_v;
			cnt_q  <= cnt_v;
			over_q <= over_v;
			win_q  <= win_v;
			prev_q <= prev_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			fcnt_q   <= fcnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res_v[0];
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= res_v[1];
		end
	end

	assign token_valid     = fcnt_q != '0;
	assign token_kind      = fifo_q[rd_ptr_q].kind;
	assign keyword_index   = fifo_q[rd_ptr_q].kw;
	assign text_char       = fifo_q[rd_ptr_q].chr;
	assign line_number     = fifo_q[rd_ptr_q].line;
	assign text_length     = fifo_q[rd_ptr_q].len;
	assign length_overflow = fifo_q[rd_ptr_q].ovf;
	assign last_of_run     = fifo_q[rd_ptr_q].last;

`ifndef NO_ASSERTIONS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= CNT_W'(sts_pkg::FIFO_DEPTH))
		else $error("output queue overfilled");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |=> token_valid)
		else $error("pushed word not presented");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_kind == sts_pkg::KIND_DONE) |-> last_of_run)
		else $error("done word not final of its byte");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != 16'd0)
		else $error("line counter reached zero");
`endif

endmodule

/* tb/script_token_scanner_chk.sv */
`timescale 1ns / 1ps

module script_token_scanner_chk #(
	parameter int MAX_TOKEN_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	input  logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        token_valid,
	input  logic        token_stall,
	input  logic [4:0]  token_kind,
	input  logic [4:0]  keyword_index,
	input  logic [7:0]  text_char,
	input  logic [15:0] line_number,
	input  logic [5:0]  text_length,
	input  logic        length_overflow,
	input  logic        last_of_run,
	output int          failures,
	output int          pending,
	output int          checked
);

	localparam logic [63:0] RESERVED [sts_pkg::KEYWORD_COUNT] = '{
		"if", "else", "endif", "for", "while", "switch", "case", "do",
		"break", "continue", "goto", "unsigned", "enum", "typedef", "struct",
		"include", "define", "state", "cts", "stc", "start", "end"
	};

	sts_pkg::mode_t mode;
	logic [63:0]    kw_window;
	int             tok_len;
	logic           tok_over;
	logic [7:0]     last_byte;
	logic [15:0]    line_no;
	sts_pkg::res_t  step_words[$];
	sts_pkg::res_t  tokens_due[$];

	function automatic bit is_letter(logic [7:0] b);
		return (b >= sts_pkg::CH_LC_A && b <= sts_pkg::CH_LC_Z) ||
			(b >= sts_pkg::CH_UC_A && b <= sts_pkg::CH_UC_Z);
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= sts_pkg::CH_ZERO && b <= sts_pkg::CH_NINE;
	endfunction

	function automatic void put_word(sts_pkg::kind_t k, logic [4:0] kw, logic [7:0] ch,
			logic [5:0] len, logic ovf);
		sts_pkg::res_t r;
		r.kind = k;
		r.kw   = kw;
		r.chr  = ch;
		r.line = line_no;
		r.len  = len;
		r.ovf  = ovf;
		r.last = 1'b0;
		step_words.push_back(r);
	endfunction

	function automatic void put_simple(sts_pkg::kind_t k);
		put_word(k, 5'd0, 8'd0, 6'd0, 1'b0);
	endfunction

	function automatic void bump_line();
		if (line_no != 16'hFFFF)
			line_no++;
	endfunction

	function automatic void clear_token();
		tok_len   = 0;
		tok_over  = 1'b0;
		kw_window = '0;
		last_byte = '0;
	endfunction

	function automatic void append_char(logic [7:0] b);
		if (tok_len < MAX_TOKEN_LEN) begin
			tok_len++;
			put_word(sts_pkg::KIND_TEXT, 5'd0, b, 6'(tok_len), 1'b0);
		end else begin
			tok_over = 1'b1;
		end
		kw_window = {kw_window[55:0], b};
		last_byte = b;
	endfunction

	function automatic int reserved_match();
		if (tok_over || tok_len > 8)
			return -1;
		for (int i = 0; i < sts_pkg::KEYWORD_COUNT; i++)
			if (kw_window == RESERVED[i])
				return i;
		return -1;
	endfunction

	function automatic void close_token(sts_pkg::kind_t k);
		int idx;
		idx = (k == sts_pkg::KIND_IDENT) ? reserved_match() : -1;
		if (idx >= 0)
			put_word(sts_pkg::KIND_KEYWORD, 5'(idx), 8'd0, 6'(tok_len), tok_over);
		else
			put_word(k, 5'd0, 8'd0, 6'(tok_len), tok_over);
		clear_token();
		mode = sts_pkg::MODE_START;
	endfunction

	function automatic void scan_fresh(logic [7:0] b);
		mode = sts_pkg::MODE_START;
		case (b)
			sts_pkg::CH_NUL: begin
				put_simple(sts_pkg::KIND_DONE);
				line_no = 16'd1;
			end
			sts_pkg::CH_LF: bump_line();
			sts_pkg::CH_SPACE, sts_pkg::CH_TAB, sts_pkg::CH_CR: begin
			end
			sts_pkg::CH_QUOTE: begin
				clear_token();
				mode = sts_pkg::MODE_STRING;
			end
			sts_pkg::CH_EQ:     mode = sts_pkg::MODE_EQ;
			sts_pkg::CH_LT:     mode = sts_pkg::MODE_LT;
			sts_pkg::CH_GT:     mode = sts_pkg::MODE_GT;
			sts_pkg::CH_AMP:    mode = sts_pkg::MODE_AMP;
			sts_pkg::CH_BAR:    mode = sts_pkg::MODE_BAR;
			sts_pkg::CH_SLASH:  mode = sts_pkg::MODE_SLASH;
			sts_pkg::CH_COLON:  put_simple(sts_pkg::KIND_COLON);
			sts_pkg::CH_SEMI:   put_simple(sts_pkg::KIND_SEMI);
			sts_pkg::CH_HASH:   put_simple(sts_pkg::KIND_HASH);
			sts_pkg::CH_LBRACE: put_simple(sts_pkg::KIND_LBRACE);
			sts_pkg::CH_RBRACE: put_simple(sts_pkg::KIND_RBRACE);
			sts_pkg::CH_LPAREN: put_simple(sts_pkg::KIND_LPAREN);
			sts_pkg::CH_RPAREN: put_simple(sts_pkg::KIND_RPAREN);
			sts_pkg::CH_COMMA:  put_simple(sts_pkg::KIND_COMMA);
			sts_pkg::CH_DOLLAR: put_simple(sts_pkg::KIND_DOLLAR);
			default: begin
				if (is_letter(b)) begin
					clear_token();
					mode = sts_pkg::MODE_IDENT;
					append_char(b);
				end else if (is_digit(b)) begin
					clear_token();
					mode = sts_pkg::MODE_NUMBER;
					append_char(b);
				end else begin
					put_simple(sts_pkg::KIND_ERROR);
				end
			end
		endcase
	endfunction

	function automatic void op_pair(logic [7:0] b, logic [7:0] second,
			sts_pkg::kind_t pair_k, sts_pkg::kind_t single_k);
		mode = sts_pkg::MODE_START;
		if (b == second) begin
			put_simple(pair_k);
		end else begin
			put_simple(single_k);
			scan_fresh(b);
		end
	endfunction

	function automatic void scan_byte(logic [7:0] b);
		case (mode)
			sts_pkg::MODE_IDENT: begin
				if (is_letter(b) || is_digit(b) || b == sts_pkg::CH_UNDER) begin
					append_char(b);
				end else begin
					close_token(sts_pkg::KIND_IDENT);
					scan_fresh(b);
				end
			end
			sts_pkg::MODE_NUMBER: begin
				if (is_digit(b) || b == sts_pkg::CH_DOT ||
						((b == sts_pkg::CH_LC_X || b == sts_pkg::CH_UC_X) &&
						last_byte == sts_pkg::CH_ZERO)) begin
					append_char(b);
				end else begin
					close_token(sts_pkg::KIND_NUMBER);
					scan_fresh(b);
				end
			end
			sts_pkg::MODE_STRING: begin
				if (b == sts_pkg::CH_QUOTE) begin
					close_token(sts_pkg::KIND_LITERAL);
				end else if (b == sts_pkg::CH_NUL) begin
					put_simple(sts_pkg::KIND_ERROR);
					clear_token();
					scan_fresh(b);
				end else begin
					append_char(b);
					if (b == sts_pkg::CH_LF)
						bump_line();
				end
			end
			sts_pkg::MODE_EQ:
				op_pair(b, sts_pkg::CH_EQ, sts_pkg::KIND_EQ, sts_pkg::KIND_ASSIGN);
			sts_pkg::MODE_LT:
				op_pair(b, sts_pkg::CH_EQ, sts_pkg::KIND_LE, sts_pkg::KIND_LT);
			sts_pkg::MODE_GT:
				op_pair(b, sts_pkg::CH_EQ, sts_pkg::KIND_GE, sts_pkg::KIND_GT);
			sts_pkg::MODE_AMP:
				op_pair(b, sts_pkg::CH_AMP, sts_pkg::KIND_ANDAND, sts_pkg::KIND_AMP);
			sts_pkg::MODE_BAR:
				op_pair(b, sts_pkg::CH_BAR, sts_pkg::KIND_OROR, sts_pkg::KIND_BAR);
			sts_pkg::MODE_SLASH: begin
				if (b == sts_pkg::CH_SLASH) begin
					mode = sts_pkg::MODE_LINEC;
				end else if (b == sts_pkg::CH_STAR) begin
					mode = sts_pkg::MODE_BLOCK;
				end else begin
					put_simple(sts_pkg::KIND_SLASH);
					scan_fresh(b);
				end
			end
			sts_pkg::MODE_LINEC: begin
				if (b == sts_pkg::CH_NUL) begin
					scan_fresh(b);
				end else if (b == sts_pkg::CH_LF) begin
					bump_line();
					mode = sts_pkg::MODE_START;
				end
			end
			sts_pkg::MODE_BLOCK, sts_pkg::MODE_BSTAR: begin
				if (b == sts_pkg::CH_NUL) begin
					scan_fresh(b);
				end else if (b == sts_pkg::CH_SLASH && mode == sts_pkg::MODE_BSTAR) begin
					mode = sts_pkg::MODE_START;
				end else if (b == sts_pkg::CH_STAR) begin
					mode = sts_pkg::MODE_BSTAR;
				end else begin
					if (b == sts_pkg::CH_LF)
						bump_line();
					mode = sts_pkg::MODE_BLOCK;
				end
			end
			default: scan_fresh(b);
		endcase
	endfunction

	function automatic void predict(logic [7:0] b);
		sts_pkg::res_t r;
		step_words.delete();
		scan_byte(b);
		for (int i = 0; i < step_words.size(); i++) begin
			r = step_words[i];
			r.last = (i == step_words.size() - 1);
			tokens_due.push_back(r);
		end
	endfunction

	function automatic void check_field(string name, logic [15:0] want_v,
			logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sts_pkg::res_t want;
		if (!arst_n) begin
			mode    = sts_pkg::MODE_START;
			line_no = 16'd1;
			clear_token();
			tokens_due.delete();
			failures = 0;
			checked  = 0;
			pending <= 0;
		end else begin
			if (char_valid && !char_stall)
				predict(char_code);
			if (token_valid && !token_stall) begin
				if (tokens_due.size() == 0) begin
					$error("token word with nothing expected: kind %0d", token_kind);
					failures++;
				end else begin
					want = tokens_due.pop_front();
					check_field("token_kind", 16'(want.kind), 16'(token_kind));
					check_field("keyword_index", 16'(want.kw), 16'(keyword_index));
					check_field("text_char", 16'(want.chr), 16'(text_char));
					check_field("line_number", want.line, line_number);
					check_field("text_length", 16'(want.len), 16'(text_length));
					check_field("length_overflow", 16'(want.ovf), 16'(length_overflow));
					check_field("last_of_run", 16'(want.last), 16'(last_of_run));
					checked++;
				end
			end
			pending <= tokens_due.size();
		end
	end

endmodule

/* tb/script_token_scanner_tb.sv */
`timescale 1ns / 1ps

module script_token_scanner_tb;

	localparam int TOKEN_MAX    = 32;
	localparam int RANDOM_BYTES = 700;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  char_code = 8'h00;
	logic        token_valid;
	logic        token_stall = 1'b0;
	logic [4:0]  token_kind;
	logic [4:0]  keyword_index;
	logic [7:0]  text_char;
	logic [15:0] line_number;
	logic [5:0]  text_length;
	logic        length_overflow;
	logic        last_of_run;

	int failures;
	int pending;
	int checked;
	bit gaps_on = 1'b0;
	bit drained_mid = 1'b0;
	int stall_left = 0;
	int bytes_fed = 0;

	string letters     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
	string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
	string digits      = "0123456789";
	string num_chars   = "0123456789.xX0";
	string op_heads    = "=<>&|/";
	string punct_chars = ":;#{}(),$";
	string blank_chars = " \t\r\n";
	string odd_chars   = "!%'+-?@[\\]^`~";
	string cmt_chars   = "ab */\n";

	script_token_scanner #(
		.MAX_TOKEN_LEN(TOKEN_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_kind(token_kind),
		.keyword_index(keyword_index),
		.text_char(text_char),
		.line_number(line_number),
		.text_length(text_length),
		.length_overflow(length_overflow),
		.last_of_run(last_of_run)
	);

	script_token_scanner_chk #(
		.MAX_TOKEN_LEN(TOKEN_MAX)
	) scan_chk (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_kind(token_kind),
		.keyword_index(keyword_index),
		.text_char(text_char),
		.line_number(line_number),
		.text_length(text_length),
		.length_overflow(length_overflow),
		.last_of_run(last_of_run),
		.failures(failures),
		.pending(pending),
		.checked(checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			token_stall <= 1'b1;
			stall_left  <= $urandom_range(0, 2);
		end else begin
			token_stall <= 1'b0;
		end
	end

	function automatic logic [7:0] pick(string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic int token_size();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
	endfunction

	task automatic feed(logic [7:0] b);
		if (gaps_on && $urandom_range(0, 6) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_code  <= b;
		do @(posedge clk); while (char_stall);
		bytes_fed++;
	endtask

	task automatic feed_text(string s);
		for (int i = 0; i < s.len(); i++)
			feed(s[i]);
	endtask

	task automatic hold_until_drained();
		char_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic send_ident();
		int len;
		len = token_size();
		feed(pick(letters));
		repeat (len - 1) feed(pick(ident_chars));
	endtask

	// keyword, sometimes capitalized or with a trailing char so it misses
	task automatic send_keyword();
		int idx;
		bit first;
		logic [7:0] c;
		idx = $urandom_range(0, sts_pkg::KEYWORD_COUNT - 1);
		first = 1'b1;
		for (int k = sts_pkg::KW_BYTES - 1; k >= 0; k--) begin
			c = sts_pkg::KW_TEXT[idx][8*k +: 8];
			if (c != sts_pkg::CH_NUL) begin
				if (first && $urandom_range(0, 7) == 0)
					c = c - 8'h20;
				first = 1'b0;
				feed(c);
			end
		end
		if ($urandom_range(0, 3) == 0)
			feed(pick(ident_chars));
	endtask

	task automatic send_number();
		int len;
		len = token_size();
		feed(pick(digits));
		repeat (len - 1) feed(pick(num_chars));
	endtask

	task automatic send_literal();
		int len;
		logic [7:0] b;
		len = token_size() - 1;
		feed(sts_pkg::CH_QUOTE);
		repeat (len) begin
			b = 8'($urandom_range(1, 255));
			if (b == sts_pkg::CH_QUOTE)
				b = sts_pkg::CH_LF;
			feed(b);
		end
		feed(($urandom_range(0, 7) == 0) ? sts_pkg::CH_NUL : sts_pkg::CH_QUOTE);
	endtask

	task automatic send_operator();
		logic [7:0] head;
		head = pick(op_heads);
		feed(head);
		if ($urandom_range(0, 1) == 0)
			feed((head == sts_pkg::CH_AMP || head == sts_pkg::CH_BAR) ? head : sts_pkg::CH_EQ);
	endtask

	task automatic send_comment();
		logic [7:0] b;
		b = sts_pkg::CH_LC_A;
		if ($urandom_range(0, 1) == 0) begin
			feed_text("//");
			repeat ($urandom_range(0, 10)) begin
				b = 8'($urandom_range(1, 255));
				feed((b == sts_pkg::CH_LF) ? sts_pkg::CH_LC_A : b);
			end
		end else begin
			feed_text("/*");
			if ($urandom_range(0, 2) == 0)
				feed(sts_pkg::CH_SLASH);
			repeat ($urandom_range(0, 10)) feed(pick(cmt_chars));
		end
		if ($urandom_range(0, 7) == 0)
			feed(sts_pkg::CH_NUL);
		else if (b == sts_pkg::CH_NUL)
			feed(sts_pkg::CH_LF);
		else
			feed_text("*/\n");
	endtask

	task automatic send_odd();
		case ($urandom_range(0, 2))
			0: feed(pick(odd_chars));
			1: feed(8'($urandom_range(8'h7F, 8'hFF)));
			default: feed(8'($urandom_range(1, 8)));
		endcase
	endtask

	task automatic random_fragment();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 22)
			send_ident();
		else if (sel < 30)
			send_keyword();
		else if (sel < 42)
			send_number();
		else if (sel < 52)
			send_literal();
		else if (sel < 66)
			send_operator();
		else if (sel < 76)
			feed(pick(punct_chars));
		else if (sel < 82)
			send_comment();
		else if (sel < 88)
			feed(pick(blank_chars));
		else if (sel < 92)
			feed(sts_pkg::CH_NUL);
		else if (sel < 96)
			send_odd();
		else
			repeat ($urandom_range(1, 3)) feed(8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on <= 1'b1;

		feed_text("if(x<=9){\"q\n\"}/*/*/$");
		feed(8'hFF);
		feed(sts_pkg::CH_NUL);
		hold_until_drained();

		while (bytes_fed < RANDOM_BYTES) begin
			gaps_on <= !(bytes_fed >= 560 || (bytes_fed >= 200 && bytes_fed < 300));
			if (!drained_mid && bytes_fed >= 400) begin
				hold_until_drained();
				drained_mid = 1'b1;
			end
			random_fragment();
			if ($urandom_range(0, 1) == 0)
				feed(pick(blank_chars));
		end
		feed(sts_pkg::CH_NUL);
		hold_until_drained();
		repeat (20) @(posedge clk);

		$display("fed %0d source bytes, compared %0d token words", bytes_fed, checked);
		$display("text had keywords, long tokens, operator pairs, comments, bad bytes, "
			, "open literals and several texts closed by a zero byte");
		if (failures == 0)
			$display("script_token_scanner_tb: done, clean");
		else
			$display("script_token_scanner_tb: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("script_token_scanner_tb: done, errors");
		$finish;
	end

endmodule

/* script_token_scanner.f */
rtl/sts_pkg.sv
rtl/script_token_scanner.sv
tb/script_token_scanner_chk.sv
tb/script_token_scanner_tb.sv
